// ===== hdl/robc_pkg.sv =====
// ============================================================================
// robc_pkg
// Shared types, constants and helpers for the row optical-black clamp.
// ============================================================================
package robc_pkg;

    localparam int LINE_WIDTH_DEF   = 1312;

    // Black geometry
    localparam int LEAD_FULL        = 14;
    localparam int LEAD_HALF        = 7;
    localparam int TRAIL_FULL       = 7;
    localparam int TRAIL_HALF       = 4;

    // Black sum and level
    localparam int SUM_W            = 13;
    localparam logic [SUM_W-1:0] SUM_MAX = 13'd8191;
    // floor(x * 6554 / 2^16) equals floor(x / 10) for every 13-bit x
    localparam logic [12:0] RECIP_10 = 13'd6554;
    localparam int RECIP_SHIFT      = 16;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    // Correction
    localparam logic [7:0] PIX_OFFSET      = 8'd10;
    localparam logic [9:0] GAIN_LIMIT      = 10'd800;
    localparam logic [7:0] CUTOFF_HIGH     = 8'd200;
    localparam logic [7:0] CUTOFF_NORMAL   = 8'd245;
    localparam logic [7:0] PIX_MAX         = 8'd255;

    // Frame length
    localparam logic [10:0] FRAME_ROWS_MAX = 11'd1024;
    localparam logic [10:0] FRAME_ROWS_MIN = 11'd1;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_FRAME = 2'd2;

    // Per-item tag carried from the control stage to the correction stage
    typedef struct packed {
        logic       has_result;
        logic       lead;
        logic       last;
        logic       frame;
        logic [7:0] level;
        logic       high_gain;
    } tag_t;

    // Black level: floor(sum / divisor) with saturation; divisor 10 or 20
    function automatic logic [7:0] black_level(input logic [SUM_W-1:0] sum,
                                               input logic half);
        logic [SUM_W-1:0]        x;
        logic [2*SUM_W-1:0]      prod;
        logic [2*SUM_W-1:0]      q;
        x    = half ? sum : (sum >> 1);
        prod = x * RECIP_10;
        q    = prod >> RECIP_SHIFT;
        if (q > {{(2*SUM_W-8){1'b0}}, LEVEL_MAX})
            return LEVEL_MAX;
        return q[7:0];
    endfunction

endpackage

// ===== hdl/robc_line_mem.sv =====
// ============================================================================
// robc_line_mem
// Single line store: one write and one registered read per cycle, read-first.
// ============================================================================
module robc_line_mem #(
    parameter int DEPTH = robc_pkg::LINE_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Same-address read and write in one cycle returns the old entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/robc_ctrl.sv =====
// ============================================================================
// robc_ctrl
// Column and row counters, black sum, level hold and line store addressing.
// ============================================================================
module robc_ctrl #(
    parameter int LINE_WIDTH = robc_pkg::LINE_WIDTH_DEF,
    parameter int CW         = $clog2(LINE_WIDTH),
    parameter int WW         = $clog2(LINE_WIDTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             op,
    input  logic [7:0]       pixel_in,
    input  logic             half_width,
    input  logic [9:0]       camera_gain,
    input  logic [10:0]      rows_per_frame,
    output logic             mem_we,
    output logic [CW-1:0]    mem_waddr,
    output logic [7:0]       mem_wdata,
    output logic             mem_re,
    output logic [CW-1:0]    mem_raddr,
    output robc_pkg::tag_t   tag
);

    localparam logic [WW-1:0] W_FULL = WW'(LINE_WIDTH);
    localparam logic [WW-1:0] W_HALF = WW'(LINE_WIDTH / 2);

    logic [CW-1:0]              col_reg, col_next;
    logic [CW-1:0]              ocol_reg, ocol_next;
    logic [robc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [7:0]                 lvl_reg, lvl_next;
    logic                       pending_reg, pending_next;
    logic [9:0]                 rows_reg, rows_next;

    logic [WW-1:0] w, w_last, lead, trail_start;
    logic [WW-1:0] oc, c;
    logic          o_last, o_frame, c_last, c_black, pix;
    logic [10:0]   frame_rows, rows_inc;
    logic [robc_pkg::SUM_W:0] sum_add;

    always_comb
    begin
        w           = half_width ? W_HALF : W_FULL;
        w_last      = w - WW'(1);
        lead        = half_width ? WW'(robc_pkg::LEAD_HALF) : WW'(robc_pkg::LEAD_FULL);
        trail_start = w - (half_width ? WW'(robc_pkg::TRAIL_HALF)
                                      : WW'(robc_pkg::TRAIL_FULL));

        oc = (WW'(ocol_reg) >= w) ? w_last : WW'(ocol_reg);
        c  = (WW'(col_reg) >= w) ? w_last : WW'(col_reg);

        if (rows_per_frame == 11'd0)
            frame_rows = robc_pkg::FRAME_ROWS_MIN;
        else if (rows_per_frame > robc_pkg::FRAME_ROWS_MAX)
            frame_rows = robc_pkg::FRAME_ROWS_MAX;
        else
            frame_rows = rows_per_frame;

        rows_inc = {1'b0, rows_reg} + 11'd1;
        o_last   = (oc >= w_last);
        o_frame  = o_last && (rows_inc >= frame_rows);

        pix     = accept && (op == robc_pkg::OP_PIXEL);
        c_last  = (c >= w_last);
        c_black = (c < lead) || ((c >= trail_start) && (c < w_last));
        sum_add = {1'b0, sum_reg} + {{(robc_pkg::SUM_W-7){1'b0}}, pixel_in};
    end

    // Line store ports: read the pending row, write the arriving pixel
    assign mem_re    = accept && pending_reg;
    assign mem_raddr = oc[CW-1:0];
    assign mem_we    = pix;
    assign mem_waddr = c[CW-1:0];
    assign mem_wdata = pixel_in;

    always_comb
    begin
        tag.has_result = pending_reg;
        tag.lead       = (oc < lead);
        tag.last       = o_last;
        tag.frame      = o_frame;
        tag.level      = lvl_reg;
        tag.high_gain  = (camera_gain > robc_pkg::GAIN_LIMIT);
    end

    always_comb
    begin
        col_next     = col_reg;
        ocol_next    = ocol_reg;
        sum_next     = sum_reg;
        lvl_next     = lvl_reg;
        pending_next = pending_reg;
        rows_next    = rows_reg;

        // Output side first: advance or close the pending row
        if (accept && pending_reg)
        begin
            if (o_last)
            begin
                pending_next = 1'b0;
                ocol_next    = '0;
                rows_next    = o_frame ? 10'd0 : rows_inc[9:0];
            end
            else
            begin
                ocol_next = oc[CW-1:0] + CW'(1);
            end
        end

        // Input side: store, sum black columns, close the row
        if (pix)
        begin
            if (c_last)
            begin
                lvl_next     = robc_pkg::black_level(sum_reg, half_width);
                sum_next     = '0;
                col_next     = '0;
                pending_next = 1'b1;
                ocol_next    = '0;
            end
            else
            begin
                col_next = c[CW-1:0] + CW'(1);
                if (c_black)
                begin
                    sum_next = sum_add[robc_pkg::SUM_W] ? robc_pkg::SUM_MAX
                                                        : sum_add[robc_pkg::SUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            ocol_reg    <= '0;
            sum_reg     <= '0;
            lvl_reg     <= '0;
            pending_reg <= 1'b0;
            rows_reg    <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            ocol_reg    <= ocol_next;
            sum_reg     <= sum_next;
            lvl_reg     <= lvl_next;
            pending_reg <= pending_next;
            rows_reg    <= rows_next;
        end
    end

    a_idle_out_col: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> (ocol_reg == '0))
        else $error("output column nonzero with no row pending");

    a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
        (pix && c_last) |=> (pending_reg && (sum_reg == '0) && (col_reg == '0)))
        else $error("row close did not arm output and clear sum");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(col_reg) < W_FULL) && (WW'(ocol_reg) < W_FULL))
        else $error("column counter out of range");

endmodule

// ===== hdl/robc_correct.sv =====
// ============================================================================
// robc_correct
// Offset, black subtract and clip on line store data (leading black columns pass raw); output register.
// ============================================================================
module robc_correct (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  robc_pkg::tag_t tag_in,
    input  logic [7:0]     rd_data,
    output logic           busy,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     pixel_out,
    output logic           row_end,
    output logic           frame_end
);

    logic           s1_v_reg, s1_v_next;
    robc_pkg::tag_t s1_tag_reg;
    logic           o_v_reg, o_v_next;
    logic [7:0]     o_pix_reg;
    logic           o_row_reg, o_frame_reg;

    logic              o_free, o_load;
    logic signed [10:0] t;
    logic [7:0]        cutoff, corr;

    assign o_free = !o_v_reg || !out_stall;
    assign o_load = s1_v_reg && o_free;
    assign busy   = s1_v_reg && !o_free;

    always_comb
    begin
        cutoff = s1_tag_reg.high_gain ? robc_pkg::CUTOFF_HIGH : robc_pkg::CUTOFF_NORMAL;
        t = $signed({3'b000, rd_data}) + $signed({3'b000, robc_pkg::PIX_OFFSET})
            - $signed({3'b000, s1_tag_reg.level});
        if (s1_tag_reg.lead)
            corr = rd_data;
        else if (t > $signed({3'b000, cutoff}))
            corr = robc_pkg::PIX_MAX;
        else if (t < 11'sd0)
            corr = 8'd0;
        else
            corr = t[7:0];
    end

    always_comb
    begin
        if (accept)
            s1_v_next = tag_in.has_result;
        else if (o_load)
            s1_v_next = 1'b0;
        else
            s1_v_next = s1_v_reg;

        if (o_load)
            o_v_next = 1'b1;
        else if (!out_stall)
            o_v_next = 1'b0;
        else
            o_v_next = o_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            o_v_reg  <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tag_reg <= tag_in;
        end
        if (o_load)
        begin
            o_pix_reg   <= corr;
            o_row_reg   <= s1_tag_reg.last;
            o_frame_reg <= s1_tag_reg.frame;
        end
    end

    assign out_valid = o_v_reg;
    assign pixel_out = o_pix_reg;
    assign row_end   = o_row_reg;
    assign frame_end = o_frame_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (s1_v_reg && $stable(s1_tag_reg)))
        else $error("blocked result left the read stage");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept)
        else $error("item taken while read stage blocked");

    a_frame_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && o_frame_reg) |-> o_row_reg)
        else $error("frame end without row end");

endmodule

// ===== hdl/row_optical_black_clamp.sv =====
// Path: a transfer reads the line store into the read stage, then the output
//   register; each row's pixels leave while the next row arrives (one row late).
// Throughput: one item per cycle when not stalled; one line store read and write
//   each cycle, read-first, so output and input of the same column share a cycle.
// Reset: counters, black sum, level and valid flags clear at once; the line
//   store is not cleared and needs no clearing pass.
// ============================================================================
// row_optical_black_clamp
// Per-row black level correction of a raster pixel stream using one line store.
// ============================================================================
module row_optical_black_clamp #(
    parameter int LINE_WIDTH = robc_pkg::LINE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [robc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [robc_pkg::CFG_DATA_W-1:0] cfg_data,

    // Pixel input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  pixel_in,

    // Corrected output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_out,
    output logic        row_end,
    output logic        frame_end
);

    localparam int CW = $clog2(LINE_WIDTH);

    // Configuration registers
    logic        half_width_reg;
    logic [9:0]  camera_gain_reg;
    logic [10:0] rows_per_frame_reg;

    logic           accept;
    logic           busy;
    logic           mem_we, mem_re;
    logic [CW-1:0]  mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_rdata;
    robc_pkg::tag_t tag;

    // Writes are always taken; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg     <= 1'b0;
            camera_gain_reg    <= '0;
            rows_per_frame_reg <= robc_pkg::FRAME_ROWS_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                robc_pkg::REG_HALF_WIDTH:     half_width_reg     <= cfg_data[0];
                robc_pkg::REG_CAMERA_GAIN:    camera_gain_reg    <= cfg_data[9:0];
                robc_pkg::REG_ROWS_PER_FRAME: rows_per_frame_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Stall input only while a finished result is blocked in the read stage
    // and the output register is still held.
    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;

    // Counters and addressing: a transfer reads the pending row, if any, at the
    // output column, and a pixel transfer writes the new pixel at the input column.
    robc_ctrl #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (op),
        .pixel_in       (pixel_in),
        .half_width     (half_width_reg),
        .camera_gain    (camera_gain_reg),
        .rows_per_frame (rows_per_frame_reg),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .tag            (tag)
    );

    // Line store, read-first on a shared column
    robc_line_mem #(
        .DEPTH (LINE_WIDTH),
        .AW    (CW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Correction and output register
    robc_correct u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .tag_in    (tag),
        .rd_data   (mem_rdata),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    a_read_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> !busy)
        else $error("line store read issued with blocked read stage");

    a_write_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (accept && (op == robc_pkg::OP_PIXEL)))
        else $error("line store written without a pixel transfer");

    a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_re && !out_valid) |=> ##1 out_valid)
        else $error("read did not reach the output");

endmodule

// ===== tb/tb_row_optical_black_clamp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_row_optical_black_clamp
// Self-checking bench for the row optical-black clamp: drives pixel rows and
// flush ticks with random gaps, predicts each corrected pixel with its own
// row model and compares every output transfer against that prediction.
// ============================================================================
module tb_row_optical_black_clamp;

    localparam int LW             = robc_pkg::LINE_WIDTH_DEF;
    localparam int DIV_FULL       = 20;
    localparam int DIV_HALF       = 10;
    localparam int LATENCY_PAD    = 4;     // output register sits behind the read stage of a transfer
    localparam int END_PAD        = 16;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    // Longest quiet stretch in a correct run is the hold-off; random gaps are shorter.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;

    typedef enum int
    {
        PAT_RANDOM,
        PAT_HOT_BLACK,     // black columns at full scale, ramp elsewhere
        PAT_COLD_BLACK,    // black columns at zero, ramp elsewhere
        PAT_TEN_BLACK      // black level equal to the offset, so output equals input below the cutoff
    } row_pattern_t;

    typedef struct packed
    {
        logic [7:0] pixel;
        logic       row_end;
        logic       frame_end;
    } clamp_out_t;

    // ------------------------------------------------------------------------
    // Clock and DUT connections; every input holds a known value from time 0
    // ------------------------------------------------------------------------
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [robc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [robc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic                             op        = robc_pkg::OP_PIXEL;
    logic [7:0]                       pixel_in  = 8'd0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [7:0]                       pixel_out;
    logic                             row_end;
    logic                             frame_end;

    initial
    begin
        forever #4 clk = ~clk;
    end

    row_optical_black_clamp u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    // ------------------------------------------------------------------------
    // Row model state: a copy of the line store, counters and the registers
    // ------------------------------------------------------------------------
    logic [7:0]   sh_line [0:LW-1];
    int unsigned  sh_col     = 0;
    int unsigned  sh_out_col = 0;
    int unsigned  sh_sum     = 0;
    int unsigned  sh_level   = 0;
    logic         sh_pending = 1'b0;
    logic [9:0]   sh_rows    = '0;

    logic         cfg_half   = 1'b0;
    logic [9:0]   cfg_gain   = '0;
    logic [10:0]  cfg_rows   = robc_pkg::FRAME_ROWS_MAX;

    clamp_out_t   corrected_q[$];   // corrected pixels still owed by the block
    int unsigned  fail_count   = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  send_quiet   = 0;
    int unsigned  recv_quiet   = 0;
    logic         hurry        = 1'b0;   // sender offers back to back
    logic         hold_req     = 1'b0;   // receiver holds off once for a long stretch
    logic [7:0]   row_dark     = 8'd0;

    function automatic int unsigned row_len();
        return cfg_half ? LW / 2 : LW;
    endfunction

    function automatic logic black_col(input int unsigned c, input int unsigned w);
        if (cfg_half)
            return (c < robc_pkg::LEAD_HALF) ||
                   (c + robc_pkg::TRAIL_HALF >= w && c + 2 <= w);
        return (c < robc_pkg::LEAD_FULL) ||
               (c + robc_pkg::TRAIL_FULL >= w && c + 2 <= w);
    endfunction

    function automatic int unsigned frame_len();
        if (cfg_rows < robc_pkg::FRAME_ROWS_MIN)
            return robc_pkg::FRAME_ROWS_MIN;
        if (cfg_rows > robc_pkg::FRAME_ROWS_MAX)
            return robc_pkg::FRAME_ROWS_MAX;
        return cfg_rows;
    endfunction

    // Advance the row model by one accepted item and queue the pixel it emits.
    // The pending row goes out first, then the new pixel is stored.
    task automatic predict_clamp(input logic op_i, input logic [7:0] px);
        int unsigned w;
        int unsigned oc;
        int unsigned c;
        int unsigned lvl;
        int          t;
        int          cutoff;
        logic        last;
        logic        frm;
        clamp_out_t  r;
        w = row_len();
        if (sh_pending)
        begin
            oc   = (sh_out_col >= w) ? w - 1 : sh_out_col;
            t    = int'(sh_line[oc]);
            last = (oc >= w - 1);
            frm  = last && (int'(sh_rows) + 1 >= frame_len());
            // leading black columns pass raw, everything after is corrected
            if (oc >= (cfg_half ? robc_pkg::LEAD_HALF : robc_pkg::LEAD_FULL))
            begin
                cutoff = (cfg_gain > robc_pkg::GAIN_LIMIT) ? int'(robc_pkg::CUTOFF_HIGH)
                                                           : int'(robc_pkg::CUTOFF_NORMAL);
                t = t + int'(robc_pkg::PIX_OFFSET) - int'(sh_level);
                if (t > cutoff)
                    t = int'(robc_pkg::PIX_MAX);
                if (t < 0)
                    t = 0;
            end
            r.pixel     = 8'(t);
            r.row_end   = last;
            r.frame_end = frm;
            corrected_q.push_back(r);
            if (last)
            begin
                sh_pending = 1'b0;
                sh_out_col = 0;
                sh_rows    = frm ? '0 : sh_rows + 1'b1;
            end
            else
            begin
                sh_out_col = oc + 1;
            end
        end
        if (op_i == robc_pkg::OP_PIXEL)
        begin
            // a column past the current width (after a mode change) ends the row
            c = (sh_col >= w) ? w - 1 : sh_col;
            sh_line[c] = px;
            if (black_col(c, w))
                sh_sum = (sh_sum + px > robc_pkg::SUM_MAX) ? robc_pkg::SUM_MAX
                                                           : sh_sum + px;
            if (c >= w - 1)
            begin
                lvl        = sh_sum / (cfg_half ? DIV_HALF : DIV_FULL);
                sh_level   = (lvl > robc_pkg::LEVEL_MAX) ? robc_pkg::LEVEL_MAX : lvl;
                sh_sum     = 0;
                sh_col     = 0;
                sh_pending = 1'b1;
                sh_out_col = 0;
            end
            else
            begin
                sh_col = c + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Wait before the next transfer: zero inside a quiet run, else zero or a random draw.
    function automatic int unsigned draw_wait(inout int unsigned quiet_left);
        if (quiet_left != 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet_left = $urandom_range(20, 300);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    function automatic logic [7:0] pick_pixel(input row_pattern_t pat);
        int unsigned w;
        int unsigned c;
        logic        dark;
        int          v;
        w    = row_len();
        c    = (sh_col >= w) ? w - 1 : sh_col;
        dark = black_col(c, w);
        case (pat)
            PAT_HOT_BLACK:  return dark ? robc_pkg::PIX_MAX : 8'(c);
            PAT_COLD_BLACK: return dark ? 8'd0 : 8'(c);
            PAT_TEN_BLACK:  return dark ? robc_pkg::PIX_OFFSET : 8'(c);
            default:
            begin
                // each row gets its own dark level, black pixels scatter around it
                if (c == 0)
                    row_dark = 8'($urandom_range(0, 255));
                if (dark)
                begin
                    v = int'(row_dark) + int'($urandom_range(0, 16)) - 8;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    return 8'(v);
                end
                case ($urandom_range(0, 7))
                    0:       return 8'd0;
                    1:       return robc_pkg::PIX_MAX;
                    default: return 8'($urandom);
                endcase
            end
        endcase
    endfunction

    // Offer one item and hold it until the transfer. Valid stays high on return
    // so a following item can go out back to back; settle drops it.
    task automatic push_item(input logic op_i, input logic [7:0] px);
        int unsigned gap;
        gap = hurry ? 0 : draw_wait(send_quiet);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_i;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_clamp(op_i, px);
    endtask

    task automatic send_pixels(input row_pattern_t pat, input int unsigned count,
                               input int unsigned flush_pct);
        for (int unsigned k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
                push_item(robc_pkg::OP_FLUSH, 8'($urandom));
            push_item(robc_pkg::OP_PIXEL, pick_pixel(pat));
        end
    endtask

    // A partial row already past a narrower width ends on its next pixel.
    task automatic send_row(input row_pattern_t pat, input int unsigned flush_pct);
        send_pixels(pat, (sh_col >= row_len()) ? 1 : row_len() - sh_col, flush_pct);
    endtask

    // Drop valid, wait until every owed pixel has come out, then let the
    // pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // Flush out the pending row so the block is idle for register writes.
    task automatic drain_rows();
        while (sh_pending)
            push_item(robc_pkg::OP_FLUSH, 8'($urandom));
        settle();
    endtask

    task automatic write_reg(input logic [robc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [robc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            robc_pkg::REG_HALF_WIDTH:     cfg_half = data[0];
            robc_pkg::REG_CAMERA_GAIN:    cfg_gain = data[9:0];
            robc_pkg::REG_ROWS_PER_FRAME: cfg_rows = data;
            default:                      ;
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Full-width rows on reset settings: saturated black level clamps most of the ramp
    // to zero, a zero black level pushes the top of the ramp past the cutoff.
    task automatic test_full_rows_clip();
        send_row(PAT_HOT_BLACK, 0);
        send_row(PAT_COLD_BLACK, 0);
        drain_rows();
    endtask

    // Output equals input here below the cutoff, so the ramp shows the cutoff on each side of
    // the gain limit.
    task automatic test_gain_cutoff();
        write_reg(robc_pkg::REG_HALF_WIDTH, 11'd1);
        write_reg(robc_pkg::REG_CAMERA_GAIN, robc_pkg::CFG_DATA_W'(robc_pkg::GAIN_LIMIT));
        send_row(PAT_TEN_BLACK, 0);
        drain_rows();
        write_reg(robc_pkg::REG_CAMERA_GAIN,
                  robc_pkg::CFG_DATA_W'(robc_pkg::GAIN_LIMIT) + 1'b1);
        send_row(PAT_TEN_BLACK, 0);
        drain_rows();
        write_reg(robc_pkg::REG_CAMERA_GAIN, 11'd1023);
        send_row(PAT_TEN_BLACK, 3);
        drain_rows();
    endtask

    // Frame marks: one-row frames, three-row frames, out-of-range lengths and
    // a row count already past a newly shortened frame.
    task automatic test_frame_marks();
        write_reg(robc_pkg::REG_ROWS_PER_FRAME, 11'd1);
        send_row(PAT_RANDOM, 5);
        send_row(PAT_RANDOM, 5);
        drain_rows();
        write_reg(robc_pkg::REG_ROWS_PER_FRAME, 11'd3);
        repeat (3) send_row(PAT_RANDOM, 5);
        drain_rows();
        write_reg(robc_pkg::REG_ROWS_PER_FRAME, 11'd2047);
        send_row(PAT_RANDOM, 5);
        send_row(PAT_RANDOM, 5);
        drain_rows();
        write_reg(robc_pkg::REG_ROWS_PER_FRAME, 11'd2);
        send_row(PAT_RANDOM, 5);
        drain_rows();
        write_reg(robc_pkg::REG_ROWS_PER_FRAME, 11'd0);
        send_row(PAT_RANDOM, 5);
        drain_rows();
    endtask

    // Width changes inside a row: growing keeps the row going, shrinking past
    // the new last column ends it at the next pixel.
    task automatic test_width_switch();
        repeat (3) push_item(robc_pkg::OP_FLUSH, 8'hFF);   // nothing pending: no output
        send_pixels(PAT_RANDOM, 300, 0);
        settle();
        write_reg(robc_pkg::REG_HALF_WIDTH, 11'd0);
        send_row(PAT_RANDOM, 2);
        drain_rows();
        send_pixels(PAT_RANDOM, 900, 0);
        settle();
        write_reg(robc_pkg::REG_HALF_WIDTH, 11'd1);
        send_pixels(PAT_RANDOM, 1, 0);
        drain_rows();
    endtask

    // Receiver holds off while the sender streams, so the block backs up and
    // stalls its input; then the sender pauses until everything owed is out.
    task automatic test_output_hold();
        write_reg(robc_pkg::REG_ROWS_PER_FRAME, 11'd4);
        send_row(PAT_RANDOM, 0);
        hold_req = 1'b1;
        hurry    = 1'b1;
        send_row(PAT_RANDOM, 0);
        hurry    = 1'b0;
        settle();
        send_row(PAT_RANDOM, 4);
        drain_rows();
    endtask

    // Random rows with random registers between phases; partial rows and
    // stray flushes carry over into the next phase.
    task automatic test_random_rows();
        logic [robc_pkg::CFG_DATA_W-1:0] gain;
        logic [robc_pkg::CFG_DATA_W-1:0] rows;
        int unsigned                     n_rows;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       gain = robc_pkg::CFG_DATA_W'(robc_pkg::GAIN_LIMIT);
                1:       gain = robc_pkg::CFG_DATA_W'(robc_pkg::GAIN_LIMIT) + 1'b1;
                2:       gain = 11'd1000;
                default: gain = robc_pkg::CFG_DATA_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 4))
                0:       rows = 11'd0;
                1:       rows = 11'd2047;
                default: rows = robc_pkg::CFG_DATA_W'($urandom_range(1, 4));
            endcase
            write_reg(robc_pkg::REG_CAMERA_GAIN, gain);
            write_reg(robc_pkg::REG_ROWS_PER_FRAME, rows);
            // mostly binned rows to keep the run short; a few full-width ones
            write_reg(robc_pkg::REG_HALF_WIDTH, (ph % 5 == 2) ? 11'd0 : 11'd1);
            n_rows = cfg_half ? $urandom_range(1, 3) : 1;
            repeat (n_rows) send_row(PAT_RANDOM, $urandom_range(0, 12));
            if ($urandom_range(0, 2) == 0)
                send_pixels(PAT_RANDOM, $urandom_range(1, row_len() - 1 - sh_col), 5);
            drain_rows();
            if ($urandom_range(0, 1) == 0)
            begin
                repeat ($urandom_range(1, 6)) push_item(robc_pkg::OP_FLUSH, 8'($urandom));
                settle();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output checker: draw a stall per result, compare each transfer against
    // the oldest prediction
    // ------------------------------------------------------------------------
    task automatic flag(input string field, input int unsigned want, input int unsigned got);
        $error("%s: expected %0d, actual %0d", field, want, got);
        fail_count++;
    endtask

    initial
    begin : result_checker
        int unsigned wait_n;
        clamp_out_t  want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                wait_n   = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                wait_n = draw_wait(recv_quiet);
            end
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (corrected_q.size() == 0)
            begin
                $error("pixel_out %0d with row_end %0b frame_end %0b came with nothing owed",
                       pixel_out, row_end, frame_end);
                fail_count++;
            end
            else
            begin
                want = corrected_q.pop_front();
                if (pixel_out !== want.pixel)
                    flag("pixel_out", want.pixel, pixel_out);
                if (row_end !== want.row_end)
                    flag("row_end", want.row_end, row_end);
                if (frame_end !== want.frame_end)
                    flag("frame_end", want.frame_end, frame_end);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transfer on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_rows_clip();
        test_gain_cutoff();
        test_frame_marks();
        test_width_switch();
        test_output_hold();
        test_random_rows();

        settle();
        repeat (END_PAD) @(posedge clk);
        if (corrected_q.size() != 0)
        begin
            $error("%0d corrected pixels never came out", corrected_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
